// ===== rtl/cia_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_pkg: shared types and constants of the interface adapter register file
// Beat payloads, command and register codes, write masks and the
// time-of-day field types used by the core and its clock unit.
// ----------------------------------------------------------------------------
package cia_pkg;

  // Commands carried by an input beat
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Register map
  localparam logic [3:0] REG_PRA   = 4'h0;
  localparam logic [3:0] REG_PRB   = 4'h1;
  localparam logic [3:0] REG_DDRA  = 4'h2;
  localparam logic [3:0] REG_DDRB  = 4'h3;
  localparam logic [3:0] REG_TALO  = 4'h4;
  localparam logic [3:0] REG_TAHI  = 4'h5;
  localparam logic [3:0] REG_TBLO  = 4'h6;
  localparam logic [3:0] REG_TBHI  = 4'h7;
  localparam logic [3:0] REG_TOD10 = 4'h8;
  localparam logic [3:0] REG_TODS  = 4'h9;
  localparam logic [3:0] REG_TODM  = 4'ha;
  localparam logic [3:0] REG_TODH  = 4'hb;
  localparam logic [3:0] REG_SDR   = 4'hc;
  localparam logic [3:0] REG_ICR   = 4'hd;
  localparam logic [3:0] REG_CRA   = 4'he;
  localparam logic [3:0] REG_CRB   = 4'hf;

  // Write masks
  localparam logic [7:0] MASK_TENTHS = 8'h0f;
  localparam logic [7:0] MASK_SIXTY  = 8'h7f;
  localparam logic [7:0] MASK_HOURS  = 8'h9f;
  localparam logic [7:0] MASK_CTRL   = 8'hef;

  // Control register bits
  localparam int CTRL_START  = 0;
  localparam int CTRL_LOAD   = 4;
  localparam int CTRL_TODIN  = 7;  // control A: 50 Hz tick source
  localparam int CTRL_ALARM  = 7;  // control B: clock writes go to the alarm

  // Interrupt flag bits
  localparam int IRQ_ALARM = 2;
  localparam int IRQ_SP    = 3;
  localparam int IRQ_ANY   = 7;

  // Tick divider reloads
  localparam logic [2:0] DIV_RELOAD_50 = 3'd4;
  localparam logic [2:0] DIV_RELOAD_60 = 3'd5;

  // Input beat
  typedef struct packed {
    logic [1:0] command;
    logic [3:0] address;
    logic [7:0] write_data;
    logic [7:0] port_a_pins;
    logic [7:0] port_b_pins;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
    logic [7:0] port_a_drive;
    logic [7:0] port_b_drive;
  } out_item_t;

  // Time-of-day fields, BCD
  typedef struct packed {
    logic [7:0] hours;
    logic [7:0] mins;
    logic [7:0] secs;
    logic [7:0] tenths;
  } tod_t;

  // Outcome of one tick
  typedef struct packed {
    tod_t       fields;
    logic [2:0] divider;
    logic       alarm_hit;
  } tod_step_t;

endpackage

// ===== rtl/cia_tod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_tod: time-of-day tick unit
// Computes the divider, the rolled BCD clock and the alarm match for one
// tick. Purely combinational; the core decides whether to commit it.
// ----------------------------------------------------------------------------
module cia_tod
  import cia_pkg::*;
(
  input  tod_t       clock_now,
  input  tod_t       alarm_now,
  input  logic       halted,
  input  logic [2:0] divider,
  input  logic       src_50hz,
  output tod_step_t  step
);

  logic [4:0] s_lo, m_lo, h_lo;
  logic [3:0] s_hi, m_hi;
  logic [1:0] h_hi;
  logic       s_wrap, m_wrap;
  logic [7:0] tenths_inc;
  logic [7:0] secs_roll, mins_roll, hours_roll;
  logic [4:0] hour_bcd;
  logic       pm;
  tod_t       rolled;

  // Seconds and minutes roll over at sixty
  always_comb begin
    s_lo = {1'b0, clock_now.secs[3:0]} + 5'd1;
    s_hi = clock_now.secs[7:4];
    if (s_lo > 5'd9) begin
      s_lo = '0;
      s_hi = s_hi + 4'd1;
    end
    s_wrap    = (s_hi > 4'd5);
    secs_roll = s_wrap ? 8'h00 : {s_hi, s_lo[3:0]};

    m_lo = {1'b0, clock_now.mins[3:0]} + 5'd1;
    m_hi = clock_now.mins[7:4];
    if (m_lo > 5'd9) begin
      m_lo = '0;
      m_hi = m_hi + 4'd1;
    end
    m_wrap    = (m_hi > 4'd5);
    mins_roll = m_wrap ? 8'h00 : {m_hi, m_lo[3:0]};
  end

  // Hours count 1..12 with the PM bit toggling at eleven to twelve
  always_comb begin
    pm       = clock_now.hours[7];
    hour_bcd = clock_now.hours[4:0];
    h_lo     = {1'b0, hour_bcd[3:0]} + 5'd1;
    h_hi     = {1'b0, hour_bcd[4]};
    if (h_lo > 5'd9) begin
      h_lo = '0;
      h_hi = h_hi + 2'd1;
    end
    priority if (hour_bcd == 5'h11) begin
      hours_roll = {~pm, 7'h12};
    end else if (hour_bcd == 5'h12) begin
      hours_roll = {pm, 7'h01};
    end else begin
      hours_roll = {pm, 2'b00, h_hi[0], h_lo[3:0]};
    end
  end

  // Advance one tenth, carrying up the chain
  always_comb begin
    tenths_inc = clock_now.tenths + 8'd1;
    rolled     = clock_now;
    if (tenths_inc > 8'd9) begin
      rolled.tenths = 8'h00;
      rolled.secs   = secs_roll;
      if (s_wrap) begin
        rolled.mins = mins_roll;
        if (m_wrap) begin
          rolled.hours = hours_roll;
        end
      end
    end else begin
      rolled.tenths = tenths_inc;
    end
  end

  // Hold while halted, count the divider down, else step the clock
  always_comb begin
    step.fields    = clock_now;
    step.divider   = divider;
    step.alarm_hit = 1'b0;
    priority if (halted) begin
      step.divider = divider;
    end else if (divider != 3'd0) begin
      step.divider = divider - 3'd1;
    end else begin
      step.divider   = src_50hz ? DIV_RELOAD_50 : DIV_RELOAD_60;
      step.fields    = rolled;
      step.alarm_hit = (rolled == alarm_now);
    end
  end

endmodule

// ===== rtl/complex_interface_adapter_regs_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_interface_adapter_regs_core: interface adapter register file
// Ports, directions, timer latches and counters, BCD time-of-day clock with
// alarm, serial data, interrupt flags and mask. One result beat per input.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   in_item  (in_item_t)
//   out_     output     out_valid / out_stall out_item (out_item_t)
//   cfg_     input      cfg_we                cfg_wdata (irq_hack)
//
// An input beat is registered in the input stage, executed against the
// register state and its result registered in the result stage.
// One beat per cycle is sustained unless out_stall holds the result stage.
// rst_n is synchronous and clears both stages and all register state.
// in_stall rises only while both stages are full and out_stall is high.
// ----------------------------------------------------------------------------
module complex_interface_adapter_regs_core
  import cia_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  // Pipeline
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  logic      out_adv;
  logic      fire;

  // Register state
  logic        irq_hack_r;
  logic [7:0]  pra_r, prb_r, ddra_r, ddrb_r;
  logic [7:0]  pra_nxt, prb_nxt, ddra_nxt, ddrb_nxt;
  logic [15:0] ta_cnt_r, tb_cnt_r, ta_lat_r, tb_lat_r;
  logic [15:0] ta_cnt_nxt, tb_cnt_nxt, ta_lat_nxt, tb_lat_nxt;
  tod_t        clk_r, alm_r, clk_nxt, alm_nxt;
  logic [7:0]  sdr_r, sdr_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [6:0]  mask_r, mask_nxt;
  logic [7:0]  cra_r, crb_r, cra_nxt, crb_nxt;
  logic        halted_r, halted_nxt;
  logic [2:0]  div_r, div_nxt;
  logic [7:0]  rd_nxt;
  out_item_t   res_nxt;

  tod_step_t   tod_step;
  in_item_t    it;
  logic [7:0]  d;
  logic [7:0]  flg;
  logic [6:0]  msk;
  tod_t        tgt;

  assign out_adv   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !out_adv;
  assign fire      = s1_valid_r && out_adv;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign it        = s1_item_r;
  assign d         = s1_item_r.write_data;

  cia_tod u_tod (
    .clock_now (clk_r),
    .alarm_now (alm_r),
    .halted    (halted_r),
    .divider   (div_r),
    .src_50hz  (cra_r[CTRL_TODIN]),
    .step      (tod_step)
  );

  // Execute one beat against the register state
  always_comb begin
    pra_nxt    = pra_r;
    prb_nxt    = prb_r;
    ddra_nxt   = ddra_r;
    ddrb_nxt   = ddrb_r;
    ta_cnt_nxt = ta_cnt_r;
    tb_cnt_nxt = tb_cnt_r;
    ta_lat_nxt = ta_lat_r;
    tb_lat_nxt = tb_lat_r;
    clk_nxt    = clk_r;
    alm_nxt    = alm_r;
    sdr_nxt    = sdr_r;
    flags_nxt  = flags_r;
    mask_nxt   = mask_r;
    cra_nxt    = cra_r;
    crb_nxt    = crb_r;
    halted_nxt = halted_r;
    div_nxt    = div_r;
    rd_nxt     = 8'h00;
    flg        = flags_r;
    msk        = mask_r;
    tgt        = crb_r[CTRL_ALARM] ? alm_r : clk_r;

    unique case (it.command)
      CMD_READ: begin
        unique case (it.address)
          REG_PRA:   rd_nxt = (pra_r | ~ddra_r) & it.port_a_pins;
          REG_PRB:   rd_nxt = (prb_r | ~ddrb_r) & it.port_b_pins;
          REG_DDRA:  rd_nxt = ddra_r;
          REG_DDRB:  rd_nxt = ddrb_r;
          REG_TALO:  rd_nxt = ta_cnt_r[7:0];
          REG_TAHI:  rd_nxt = ta_cnt_r[15:8];
          REG_TBLO:  rd_nxt = tb_cnt_r[7:0];
          REG_TBHI:  rd_nxt = tb_cnt_r[15:8];
          REG_TOD10: begin
            rd_nxt     = clk_r.tenths;
            halted_nxt = 1'b0;
          end
          REG_TODS:  rd_nxt = clk_r.secs;
          REG_TODM:  rd_nxt = clk_r.mins;
          REG_TODH:  begin
            rd_nxt     = clk_r.hours;
            halted_nxt = 1'b1;
          end
          REG_SDR:   rd_nxt = sdr_r;
          REG_ICR:   begin
            rd_nxt    = flags_r;
            flags_nxt = 8'h00;
          end
          REG_CRA:   rd_nxt = cra_r;
          REG_CRB:   rd_nxt = crb_r;
          default:   rd_nxt = 8'h00;
        endcase
      end
      CMD_WRITE: begin
        unique case (it.address)
          REG_PRA:   pra_nxt  = d;
          REG_PRB:   prb_nxt  = d;
          REG_DDRA:  ddra_nxt = d;
          REG_DDRB:  ddrb_nxt = d;
          REG_TALO:  ta_lat_nxt = {ta_lat_r[15:8], d};
          REG_TAHI:  begin
            ta_lat_nxt = {d, ta_lat_r[7:0]};
            if (!cra_r[CTRL_START]) begin
              ta_cnt_nxt = {d, ta_lat_r[7:0]};
            end
          end
          REG_TBLO:  tb_lat_nxt = {tb_lat_r[15:8], d};
          REG_TBHI:  begin
            tb_lat_nxt = {d, tb_lat_r[7:0]};
            if (!crb_r[CTRL_START]) begin
              tb_cnt_nxt = {d, tb_lat_r[7:0]};
            end
          end
          REG_TOD10: tgt.tenths = d & MASK_TENTHS;
          REG_TODS:  tgt.secs   = d & MASK_SIXTY;
          REG_TODM:  tgt.mins   = d & MASK_SIXTY;
          REG_TODH:  tgt.hours  = d & MASK_HOURS;
          REG_SDR:   begin
            sdr_nxt           = d;
            flags_nxt[IRQ_SP] = 1'b1;
            if (mask_r[IRQ_SP]) begin
              flags_nxt[IRQ_ANY] = 1'b1;
            end
          end
          REG_ICR:   begin
            if (irq_hack_r) begin
              flg = 8'h00;
            end
            if (d[7]) begin
              msk = mask_r | d[6:0];
              if ((flg[4:0] & msk[4:0]) != 5'd0) begin
                flg[IRQ_ANY] = 1'b1;
              end
            end else begin
              msk = mask_r & ~d[6:0];
            end
            flags_nxt = flg;
            mask_nxt  = msk;
          end
          REG_CRA:   begin
            cra_nxt = d & MASK_CTRL;
            if (d[CTRL_LOAD]) begin
              ta_cnt_nxt = ta_lat_r;
            end
          end
          REG_CRB:   begin
            crb_nxt = d & MASK_CTRL;
            if (d[CTRL_LOAD]) begin
              tb_cnt_nxt = tb_lat_r;
            end
          end
          default:   pra_nxt = pra_r;
        endcase
        // steer clock-field writes to the alarm or the clock
        if (it.address == REG_TOD10 || it.address == REG_TODS ||
            it.address == REG_TODM || it.address == REG_TODH) begin
          if (crb_r[CTRL_ALARM]) begin
            alm_nxt = tgt;
          end else begin
            clk_nxt = tgt;
          end
        end
      end
      CMD_TICK: begin
        clk_nxt = tod_step.fields;
        div_nxt = tod_step.divider;
        if (tod_step.alarm_hit) begin
          flags_nxt[IRQ_ALARM] = 1'b1;
          if (mask_r[IRQ_ALARM]) begin
            flags_nxt[IRQ_ANY] = 1'b1;
          end
        end
      end
      default: rd_nxt = 8'h00;
    endcase

    res_nxt.read_data    = rd_nxt;
    res_nxt.irq_line     = flags_nxt[IRQ_ANY];
    res_nxt.port_a_drive = pra_nxt | ~ddra_nxt;
    res_nxt.port_b_drive = prb_nxt | ~ddrb_nxt;
  end

  // Hold pipeline, register state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      irq_hack_r  <= 1'b0;
      pra_r       <= '0;
      prb_r       <= '0;
      ddra_r      <= '0;
      ddrb_r      <= '0;
      ta_cnt_r    <= 16'hffff;
      tb_cnt_r    <= 16'hffff;
      ta_lat_r    <= 16'h0001;
      tb_lat_r    <= 16'h0001;
      clk_r       <= '0;
      alm_r       <= '0;
      sdr_r       <= '0;
      flags_r     <= '0;
      mask_r      <= '0;
      cra_r       <= '0;
      crb_r       <= '0;
      halted_r    <= 1'b0;
      div_r       <= '0;
    end else begin
      if (cfg_we) begin
        irq_hack_r <= cfg_wdata;
      end
      // advance the input stage
      if (!in_stall) begin
        s1_valid_r <= in_valid;
        if (in_valid) begin
          s1_item_r <= in_item;
        end
      end
      // advance the result stage
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          out_item_r <= res_nxt;
        end
      end
      // commit the executed beat
      if (fire) begin
        pra_r    <= pra_nxt;
        prb_r    <= prb_nxt;
        ddra_r   <= ddra_nxt;
        ddrb_r   <= ddrb_nxt;
        ta_cnt_r <= ta_cnt_nxt;
        tb_cnt_r <= tb_cnt_nxt;
        ta_lat_r <= ta_lat_nxt;
        tb_lat_r <= tb_lat_nxt;
        clk_r    <= clk_nxt;
        alm_r    <= alm_nxt;
        sdr_r    <= sdr_nxt;
        flags_r  <= flags_nxt;
        mask_r   <= mask_nxt;
        cra_r    <= cra_nxt;
        crb_r    <= crb_nxt;
        halted_r <= halted_nxt;
        div_r    <= div_nxt;
      end
    end
  end

endmodule

// ===== rtl/cia_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_chk: port checker for the adapter register core
// Watches the top-level ports for reset, back-pressure and stall behavior.
// ----------------------------------------------------------------------------
module cia_chk
  import cia_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat visible after reset");

  // input back-pressure only when the result stage is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output could drain");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result beat changed");

  // an idle output never blocks the input
  a_idle_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // a stalled input beat holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_item)))
    else $error("stalled input beat changed");

endmodule

bind complex_interface_adapter_regs_core cia_chk u_cia_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ===== test/complex_interface_adapter_regs_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_interface_adapter_regs_core_test: register file self-checking bench
// Drives bus reads, writes and time-of-day ticks through the beat handshake,
// predicts every result beat from a local copy of the register state and
// checks it field by field. Both sides stall at random, and irq_hack is
// toggled between phases.
// ----------------------------------------------------------------------------
module complex_interface_adapter_regs_core_test;
  import cia_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 4;
  localparam int TIMEOUT_NS = 2_000_000;

  // Register state of the adapter and the results it must produce
  class adapter_scoreboard;
    bit        irq_hack;
    bit [7:0]  pa_data, pb_data, pa_dir, pb_dir;
    bit [15:0] ta_count, tb_count, ta_latch, tb_latch;
    tod_t      clock_now, alarm_set;
    bit [7:0]  sdr, flags;
    bit [6:0]  mask;
    bit [7:0]  cra, crb;
    bit        halted;
    bit [2:0]  divider;
    out_item_t expected_results[$];
    int        mismatches;

    function new();
      irq_hack = 1'b0;
      pa_data = '0; pb_data = '0; pa_dir = '0; pb_dir = '0;
      ta_count = 16'hffff; tb_count = 16'hffff;
      ta_latch = 16'd1; tb_latch = 16'd1;
      clock_now = '0; alarm_set = '0;
      sdr = '0; flags = '0; mask = '0;
      cra = '0; crb = '0;
      halted = 1'b0; divider = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void raise_flag(int b);
      flags[b] = 1'b1;
      if (mask[b]) flags[IRQ_ANY] = 1'b1;
    endfunction

    // Advance a seconds or minutes BCD field; bit 8 flags the wrap to zero
    function bit [8:0] roll_sixty(bit [7:0] f);
      int lo, hi;
      lo = f[3:0] + 1;
      hi = f[7:4];
      if (lo > 9) begin
        lo = 0;
        hi++;
      end
      if (hi > 5) return 9'h100;
      return {1'b0, hi[3:0], lo[3:0]};
    endfunction

    // 12-hour BCD count with the PM bit on top
    function bit [7:0] next_hour(bit [7:0] h);
      bit [7:0] pm;
      bit [4:0] hh;
      int lo, hi;
      pm = h & 8'h80;
      hh = h[4:0];
      if (hh == 5'h11) return (pm ^ 8'h80) | 8'h12;
      if (hh == 5'h12) return pm | 8'h01;
      lo = hh[3:0] + 1;
      hi = hh[4];
      if (lo > 9) begin
        lo = 0;
        hi++;
      end
      return pm | {3'b000, hi[0], lo[3:0]};
    endfunction

    function void advance_tod();
      bit [8:0] s, m;
      if (halted) return;
      if (divider != 0) begin
        divider--;
        return;
      end
      divider = cra[CTRL_TODIN] ? DIV_RELOAD_50 : DIV_RELOAD_60;
      clock_now.tenths = clock_now.tenths + 8'd1;
      if (clock_now.tenths > 8'd9) begin
        clock_now.tenths = '0;
        s = roll_sixty(clock_now.secs);
        clock_now.secs = s[7:0];
        if (s[8]) begin
          m = roll_sixty(clock_now.mins);
          clock_now.mins = m[7:0];
          if (m[8]) clock_now.hours = next_hour(clock_now.hours);
        end
      end
      if (clock_now == alarm_set) raise_flag(IRQ_ALARM);
    endfunction

    function bit [7:0] read_reg(bit [3:0] a, bit [7:0] pins_a, bit [7:0] pins_b);
      bit [7:0] v;
      v = '0;
      case (a)
        REG_PRA:  v = (pa_data | ~pa_dir) & pins_a;
        REG_PRB:  v = (pb_data | ~pb_dir) & pins_b;
        REG_DDRA: v = pa_dir;
        REG_DDRB: v = pb_dir;
        REG_TALO: v = ta_count[7:0];
        REG_TAHI: v = ta_count[15:8];
        REG_TBLO: v = tb_count[7:0];
        REG_TBHI: v = tb_count[15:8];
        REG_TOD10: begin
          halted = 1'b0;
          v = clock_now.tenths;
        end
        REG_TODS: v = clock_now.secs;
        REG_TODM: v = clock_now.mins;
        REG_TODH: begin
          halted = 1'b1;
          v = clock_now.hours;
        end
        REG_SDR:  v = sdr;
        REG_ICR: begin
          v = flags;
          flags = '0;
        end
        REG_CRA:  v = cra;
        default:  v = crb;
      endcase
      return v;
    endfunction

    function void write_reg(bit [3:0] a, bit [7:0] d);
      bit to_alarm;
      to_alarm = crb[CTRL_ALARM];
      case (a)
        REG_PRA:  pa_data = d;
        REG_PRB:  pb_data = d;
        REG_DDRA: pa_dir = d;
        REG_DDRB: pb_dir = d;
        REG_TALO: ta_latch[7:0] = d;
        REG_TAHI: begin
          ta_latch[15:8] = d;
          if (!cra[CTRL_START]) ta_count = ta_latch;
        end
        REG_TBLO: tb_latch[7:0] = d;
        REG_TBHI: begin
          tb_latch[15:8] = d;
          if (!crb[CTRL_START]) tb_count = tb_latch;
        end
        REG_TOD10: begin
          if (to_alarm) alarm_set.tenths = d & MASK_TENTHS;
          else clock_now.tenths = d & MASK_TENTHS;
        end
        REG_TODS: begin
          if (to_alarm) alarm_set.secs = d & MASK_SIXTY;
          else clock_now.secs = d & MASK_SIXTY;
        end
        REG_TODM: begin
          if (to_alarm) alarm_set.mins = d & MASK_SIXTY;
          else clock_now.mins = d & MASK_SIXTY;
        end
        REG_TODH: begin
          if (to_alarm) alarm_set.hours = d & MASK_HOURS;
          else clock_now.hours = d & MASK_HOURS;
        end
        REG_SDR: begin
          sdr = d;
          raise_flag(IRQ_SP);
        end
        REG_ICR: begin
          if (irq_hack) flags = '0;
          if (d[7]) begin
            mask = mask | d[6:0];
            if ((flags[4:0] & mask[4:0]) != 0) flags[IRQ_ANY] = 1'b1;
          end else begin
            mask = mask & ~d[6:0];
          end
        end
        REG_CRA: begin
          cra = d & MASK_CTRL;
          if (d[CTRL_LOAD]) ta_count = ta_latch;
        end
        default: begin
          crb = d & MASK_CTRL;
          if (d[CTRL_LOAD]) tb_count = tb_latch;
        end
      endcase
    endfunction

    // Execute one accepted access and queue the result it must give
    function void note_access(in_item_t it);
      out_item_t r;
      r = '0;
      case (it.command)
        CMD_READ:  r.read_data = read_reg(it.address, it.port_a_pins, it.port_b_pins);
        CMD_WRITE: write_reg(it.address, it.write_data);
        CMD_TICK:  advance_tod();
        default: ;
      endcase
      r.irq_line = flags[IRQ_ANY];
      r.port_a_drive = pa_data | ~pa_dir;
      r.port_b_drive = pb_data | ~pb_dir;
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with no access pending: expected none, actual %h",
                 $time, got);
        return;
      end
      want = expected_results.pop_front();
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("irq_line", want.irq_line, got.irq_line);
      compare_field("port_a_drive", want.port_a_drive, got.port_a_drive);
      compare_field("port_b_drive", want.port_b_drive, got.port_b_drive);
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic      cfg_we;
  logic      cfg_wdata;

  adapter_scoreboard sb;
  bit steady = 1'b0;
  int accepted_beats = 0;
  int stall_left = 0;

  complex_interface_adapter_regs_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Check result beats and stall the output in random bursts
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_item_t make_item(logic [1:0] cmd, logic [3:0] addr,
                                         logic [7:0] data, logic [7:0] pa,
                                         logic [7:0] pb);
    in_item_t it;
    it.command = cmd;
    it.address = addr;
    it.write_data = data;
    it.port_a_pins = pa;
    it.port_b_pins = pb;
    return it;
  endfunction

  // Offer one beat, after an optional idle burst, and hold it until taken
  task automatic send_access(in_item_t it);
    if (!steady && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    sb.note_access(it);
    accepted_beats++;
  endtask

  task automatic bus_read(logic [3:0] addr);
    send_access(make_item(CMD_READ, addr, 8'($urandom), 8'($urandom), 8'($urandom)));
  endtask

  task automatic bus_write(logic [3:0] addr, logic [7:0] data);
    send_access(make_item(CMD_WRITE, addr, data, 8'($urandom), 8'($urandom)));
  endtask

  task automatic tod_tick();
    send_access(make_item(CMD_TICK, 4'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom)));
  endtask

  task automatic wait_drained();
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_irq_hack(bit v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.irq_hack = v;
    cfg_we <= 1'b0;
  endtask

  // Field extremes, every command and the special register behaviors
  task automatic run_directed();
    send_access(make_item(CMD_READ, REG_PRA, 8'h00, 8'hff, 8'hff));
    bus_write(REG_DDRA, 8'hff);
    bus_write(REG_PRA, 8'h00);
    send_access(make_item(CMD_READ, REG_PRA, 8'hff, 8'hff, 8'h00));
    bus_write(REG_PRB, 8'hff);
    bus_write(REG_DDRB, 8'h0f);
    send_access(make_item(CMD_READ, REG_PRB, 8'h00, 8'h00, 8'ha5));
    bus_read(REG_TALO);
    bus_write(REG_TALO, 8'h34);
    bus_write(REG_TAHI, 8'h12);
    bus_read(REG_TAHI);
    bus_write(REG_CRA, 8'hff);
    bus_read(REG_CRA);
    bus_write(REG_CRB, 8'h80);
    bus_write(REG_TODH, 8'hff);
    bus_write(REG_CRB, 8'h00);
    bus_write(REG_SDR, 8'h00);
    bus_write(REG_ICR, 8'h88);
    bus_read(REG_ICR);
    bus_read(REG_TODH);
    tod_tick();
    bus_read(REG_TOD10);
    tod_tick();
    send_access(make_item(CMD_UNUSED, 4'hf, 8'hff, 8'hff, 8'hff));
    send_access(make_item(CMD_READ, REG_ICR, 8'h00, 8'h00, 8'h00));
  endtask

  // Set the clock near a rollover, maybe arm the alarm, then run it
  task automatic run_tod_sequence();
    logic [7:0] h, m, s, t, tt;
    case ($urandom_range(0, 5))
      0: h = 8'h11;
      1: h = 8'h91;
      2: h = 8'h12;
      3: h = 8'h92;
      4: h = 8'h09;
      default: h = 8'($urandom);
    endcase
    m = $urandom_range(0, 1) ? 8'h59 : 8'($urandom);
    s = $urandom_range(0, 1) ? 8'h59 : 8'($urandom);
    case ($urandom_range(0, 2))
      0: t = 8'h09;
      1: t = 8'($urandom_range(0, 8));
      default: t = 8'($urandom);
    endcase
    tt = t & MASK_TENTHS;
    bus_write(REG_CRB, 8'($urandom) & 8'h7f);
    bus_write(REG_TODH, h);
    bus_write(REG_TODM, m);
    bus_write(REG_TODS, s);
    bus_write(REG_TOD10, t);
    if ($urandom_range(0, 1)) begin
      bus_write(REG_CRB, 8'h80 | (8'($urandom) & 8'h7f));
      bus_write(REG_TODH, h);
      bus_write(REG_TODM, m);
      bus_write(REG_TODS, s);
      bus_write(REG_TOD10, (tt < 8'd9) ? tt + 8'd1 : 8'($urandom_range(0, 9)));
      bus_write(REG_CRB, 8'($urandom) & 8'h7f);
    end
    bus_write(REG_ICR, $urandom_range(0, 1) ? 8'h84 : 8'($urandom));
    bus_read(REG_TOD10);
    repeat ($urandom_range(1, 16)) begin
      if ($urandom_range(0, 7) == 0) bus_read(4'($urandom_range(8, 11)));
      else tod_tick();
    end
    bus_read(REG_ICR);
    bus_read(REG_TODH);
    bus_read(REG_TODM);
    bus_read(REG_TODS);
    bus_read(REG_TOD10);
  endtask

  // Exercise the flag and mask interplay with the serial flag
  task automatic run_irq_sequence();
    bus_write(REG_ICR, 8'($urandom));
    bus_write(REG_SDR, 8'($urandom));
    if ($urandom_range(0, 1)) bus_write(REG_ICR, 8'($urandom));
    bus_read(REG_ICR);
    bus_read(REG_ICR);
  endtask

  task automatic run_random_access();
    int c;
    logic [1:0] cmd;
    c = $urandom_range(0, 19);
    if (c < 7) cmd = CMD_READ;
    else if (c < 14) cmd = CMD_WRITE;
    else if (c < 19) cmd = CMD_TICK;
    else cmd = CMD_UNUSED;
    send_access(make_item(cmd, 4'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom)));
  endtask

  task automatic run_random_phase(int count);
    int target;
    int pick;
    target = accepted_beats + count;
    while (accepted_beats < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) run_random_access();
      else if (pick < 9) run_tod_sequence();
      else run_irq_sequence();
    end
    in_valid <= 1'b0;
    wait_drained();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_irq_hack(1'b0);
    run_directed();
    in_valid <= 1'b0;
    wait_drained();
    write_irq_hack(1'b1);
    run_random_phase(240);
    write_irq_hack(1'b0);
    run_random_phase(240);
    // Last phase runs without idling on either side
    steady = 1'b1;
    write_irq_hack(1'b1);
    run_random_phase(240);
    if (sb.mismatches == 0) begin
      $display("complex_interface_adapter_regs_core_test passed");
    end else begin
      $display("complex_interface_adapter_regs_core_test failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("complex_interface_adapter_regs_core_test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cia_pkg.sv
rtl/cia_tod.sv
rtl/complex_interface_adapter_regs_core.sv
rtl/cia_chk.sv
test/complex_interface_adapter_regs_core_test.sv
